// ===== src/prss_pkg.sv =====
package prss_pkg;
	localparam int PAGE_COUNT = 16;
	localparam int SLOTS_PER_PAGE = 32;
	localparam int PAGE_W = 4;
	localparam int SLOT_W = 5;
	localparam int COUNT_W = 6;
	localparam int REC_W = 64;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;
	localparam logic [1:0] ACT_DELETE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_LIVE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	// keep mask for the low record bytes; 0 acts as 1, above 8 acts as 8
	function automatic logic [REC_W-1:0] keep_mask(input logic [3:0] nbytes);
		logic [REC_W-1:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (b == 0 || 4'(b) < nbytes) m[b*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction
endpackage

// ===== src/paged_record_slot_store_top.sv =====
// Paged record slot store: 16 pages of 32 slots, each slot a live bit and a
// 64-bit record. Insert takes the lowest free slot of the first open page that
// has one, opening the next page when all are full; get/update/delete act on
// a live slot. One transaction at a time, and the page walk sets the cost:
// insert examines pages in turn (live mask read, then free-slot check) before
// the output state and a return to idle; other actions pass through an access
// and a done state. A stalled m_tready holds the output state. The record
// words and the per-page live masks sit in synchronous memories with
// registered reads; live masks and page counts are valid-bit guarded, so no
// clearing pass follows reset. Results wait in an output register.
module paged_record_slot_store_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        record_bytes_we,
	input  logic [3:0]  record_bytes_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[1:0], page_index[5:2], slot_index[10:6], record_data[74:11]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], result_page[5:2], result_slot[10:6], read_data[74:11],
	// page_used_count[80:75]
	output logic [87:0] m_tdata
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SCHK = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [3:0] rbytes_q;
	logic [1:0] act_q;
	logic [prss_pkg::PAGE_W-1:0] page_q;
	logic [prss_pkg::SLOT_W-1:0] slot_q;
	logic [prss_pkg::REC_W-1:0] data_q;
	logic [4:0] pages_q;

	// live masks per page (memory) and record words (memory)
	logic [prss_pkg::SLOTS_PER_PAGE-1:0] live_mem [prss_pkg::PAGE_COUNT];
	logic [prss_pkg::REC_W-1:0] rec_mem [prss_pkg::PAGE_COUNT*prss_pkg::SLOTS_PER_PAGE];
	logic [prss_pkg::SLOTS_PER_PAGE-1:0] live_rd_q;
	logic [prss_pkg::REC_W-1:0] rec_rd_q;
	logic [prss_pkg::PAGE_COUNT-1:0] pvalid_q;
	logic [prss_pkg::COUNT_W-1:0] cnt_q [prss_pkg::PAGE_COUNT];

	logic [prss_pkg::SLOTS_PER_PAGE-1:0] live_mask;
	logic [prss_pkg::SLOTS_PER_PAGE-1:0] free_v;
	logic free_any;
	logic [prss_pkg::SLOT_W-1:0] free_idx;

	logic [1:0] o_st_q;
	logic [prss_pkg::PAGE_W-1:0] o_pg_q;
	logic [prss_pkg::SLOT_W-1:0] o_sl_q;
	logic [prss_pkg::REC_W-1:0] o_rd_q;
	logic [prss_pkg::COUNT_W-1:0] o_ct_q;

	logic lw_en, rw_en;
	logic [prss_pkg::SLOTS_PER_PAGE-1:0] lw_data;
	logic [prss_pkg::PAGE_W+prss_pkg::SLOT_W-1:0] rec_waddr;
	logic [prss_pkg::COUNT_W-1:0] cur_cnt;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {7'd0, o_ct_q, o_rd_q, o_sl_q, o_pg_q, o_st_q};

	assign live_mask = pvalid_q[page_q] ? live_rd_q : '0;
	assign cur_cnt = pvalid_q[page_q] ? cnt_q[page_q] : '0;

	// lowest free slot encoder
	always_comb begin
		free_v = ~live_mask;
		free_any = |free_v;
		free_idx = '0;
		for (int i = prss_pkg::SLOTS_PER_PAGE-1; i >= 0; i--) begin
			if (free_v[i]) free_idx = prss_pkg::SLOT_W'(i);
		end
	end

	// memories: read address is the current page / slot
	always_ff @(posedge clk) begin
		if (lw_en) live_mem[page_q] <= lw_data;
		if (rw_en) rec_mem[rec_waddr] <= data_q;
		live_rd_q <= live_mem[page_q];
		rec_rd_q <= rec_mem[{page_q, slot_q}];
	end

	always_comb begin
		lw_en = 1'b0;
		rw_en = 1'b0;
		lw_data = live_mask;
		rec_waddr = {page_q, slot_q};
		if (state_q == S_SCHK && act_q == prss_pkg::ACT_INSERT && free_any) begin
			lw_en = 1'b1;
			rw_en = 1'b1;
			lw_data[free_idx] = 1'b1;
			// insert lands in the slot found by the encoder
			rec_waddr = {page_q, free_idx};
		end else if (state_q == S_DONE && live_mask[slot_q]) begin
			if (act_q == prss_pkg::ACT_UPDATE) rw_en = 1'b1;
			if (act_q == prss_pkg::ACT_DELETE) begin
				lw_en = 1'b1;
				lw_data[slot_q] = 1'b0;
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rbytes_q <= 4'd8;
			pages_q <= 5'd1;
			pvalid_q <= '0;
			for (int i = 0; i < prss_pkg::PAGE_COUNT; i++) cnt_q[i] <= '0;
		end else begin
			if (record_bytes_we) rbytes_q <= record_bytes_wdata;
			case (state_q)
				S_IDLE: if (s_tvalid) begin
					act_q <= s_tdata[1:0];
					data_q <= s_tdata[74:11] & prss_pkg::keep_mask(rbytes_q);
					if (s_tdata[1:0] == prss_pkg::ACT_INSERT) begin
						page_q <= '0;
						slot_q <= '0;
						state_q <= S_SCAN;
					end else begin
						page_q <= s_tdata[5:2];
						slot_q <= s_tdata[10:6];
						state_q <= S_ACC;
					end
				end
				S_SCAN: state_q <= S_SCHK;
				S_SCHK: begin
					if (free_any) begin
						slot_q <= free_idx;
						pvalid_q[page_q] <= 1'b1;
						cnt_q[page_q] <= cur_cnt + 1'b1;
						if (5'(page_q) == pages_q) pages_q <= pages_q + 1'b1;
						o_st_q <= prss_pkg::ST_OK;
						o_pg_q <= page_q;
						o_sl_q <= free_idx;
						o_rd_q <= '0;
						o_ct_q <= cur_cnt + 1'b1;
						state_q <= S_OUT;
					end else if (5'(page_q) + 5'd1 < pages_q ||
							(5'(page_q) + 5'd1 == pages_q &&
							pages_q < 5'(prss_pkg::PAGE_COUNT))) begin
						page_q <= page_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						o_st_q <= prss_pkg::ST_FULL;
						o_pg_q <= '0;
						o_sl_q <= '0;
						o_rd_q <= '0;
						o_ct_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_ACC: state_q <= S_DONE;
				S_DONE: begin
					o_pg_q <= page_q;
					o_sl_q <= slot_q;
					o_rd_q <= '0;
					o_ct_q <= cur_cnt;
					if (!live_mask[slot_q]) begin
						o_st_q <= prss_pkg::ST_NOT_LIVE;
					end else begin
						o_st_q <= prss_pkg::ST_OK;
						if (act_q == prss_pkg::ACT_GET)
							o_rd_q <= rec_rd_q & prss_pkg::keep_mask(rbytes_q);
						if (act_q == prss_pkg::ACT_DELETE && cur_cnt != '0) begin
							cnt_q[page_q] <= cur_cnt - 1'b1;
							o_ct_q <= cur_cnt - 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/prss_checker.sv =====
`timescale 1ns / 100ps

module prss_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        record_bytes_we,
	input  logic [3:0]  record_bytes_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [5:0]  used;
		logic [63:0] rdata;
		logic [4:0]  slot;
		logic [3:0]  page;
		logic [1:0]  status;
	} reply_t;

	logic [3:0]  nbytes;
	logic        live [prss_pkg::PAGE_COUNT*prss_pkg::SLOTS_PER_PAGE];
	logic [63:0] records [prss_pkg::PAGE_COUNT*prss_pkg::SLOTS_PER_PAGE];
	logic [5:0]  used [prss_pkg::PAGE_COUNT];
	int          open_pages;
	reply_t      replies [$];

	assign pending = replies.size();

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		int k;
		k = (n == 0) ? 1 : ((n > 8) ? 8 : n);
		m = '0;
		for (int b = 0; b < k; b++) m[b*8 +: 8] = 8'hFF;
		return m;
	endfunction

	// compute the reply of one request and update the shadow store
	function automatic reply_t store_step(input logic [79:0] d);
		reply_t r;
		logic [1:0] act;
		logic [3:0] pg;
		logic [4:0] sl;
		logic [63:0] val;
		int at;
		act = d[1:0];
		pg = d[5:2];
		sl = d[10:6];
		val = d[74:11] & byte_mask(nbytes);
		r = '0;
		if (act == prss_pkg::ACT_INSERT) begin
			for (int p = 0; p < open_pages; p++)
				for (int s = 0; s < prss_pkg::SLOTS_PER_PAGE; s++) begin
					at = p*prss_pkg::SLOTS_PER_PAGE + s;
					if (!live[at]) begin
						live[at] = 1'b1;
						records[at] = val;
						used[p]++;
						r.status = prss_pkg::ST_OK;
						r.page = 4'(p);
						r.slot = 5'(s);
						r.used = used[p];
						return r;
					end
				end
			if (open_pages >= prss_pkg::PAGE_COUNT) begin
				r.status = prss_pkg::ST_FULL;
				return r;
			end
			at = open_pages*prss_pkg::SLOTS_PER_PAGE;
			live[at] = 1'b1;
			records[at] = val;
			used[open_pages] = 6'd1;
			r.status = prss_pkg::ST_OK;
			r.page = 4'(open_pages);
			r.used = 6'd1;
			open_pages++;
			return r;
		end
		r.page = pg;
		r.slot = sl;
		at = pg*prss_pkg::SLOTS_PER_PAGE + sl;
		if (!live[at]) begin
			r.status = prss_pkg::ST_NOT_LIVE;
			r.used = used[pg];
			return r;
		end
		r.status = prss_pkg::ST_OK;
		if (act == prss_pkg::ACT_GET) r.rdata = records[at] & byte_mask(nbytes);
		else if (act == prss_pkg::ACT_UPDATE) records[at] = val;
		else begin
			live[at] = 1'b0;
			if (used[pg] > 0) used[pg]--;
		end
		r.used = used[pg];
		return r;
	endfunction

	// watch config, requests and replies
	always @(posedge clk or negedge arst_n) begin
		reply_t got, want;
		if (!arst_n) begin
			nbytes <= 4'd8;
			for (int i = 0; i < prss_pkg::PAGE_COUNT*prss_pkg::SLOTS_PER_PAGE; i++)
				live[i] = 1'b0;
			for (int i = 0; i < prss_pkg::PAGE_COUNT; i++) used[i] = '0;
			open_pages = 1;
			replies.delete();
			fail_count <= 0;
		end else begin
			if (record_bytes_we) nbytes <= record_bytes_wdata;
			if (s_tvalid && s_tready) replies.push_back(store_step(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[80:0];
				if (replies.size() == 0) begin
					if (fail_count < 10) $display("unexpected reply %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = replies.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"reply mismatch: exp st=%0d pg=%0d sl=%0d rd=%h cnt=%0d,",
								" act st=%0d pg=%0d sl=%0d rd=%h cnt=%0d"},
								want.status, want.page, want.slot, want.rdata, want.used,
								got.status, got.page, got.slot, got.rdata, got.used);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        record_bytes_we = 1'b0;
	logic [3:0]  record_bytes_wdata = 4'd8;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	int          fail_count;
	int          pending;
	bit          hold_off = 1'b0;

	paged_record_slot_store_top uut (.*);
	prss_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern, plus one long hold-off on request
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				for (hold = 0; hold < 400; hold++) @(negedge clk);
				hold_off = 1'b0;
			end
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// offer one request and wait for its transaction
	task automatic send_req(input logic [1:0] act, input logic [3:0] pg,
			input logic [4:0] sl, input logic [63:0] val);
		s_tdata <= {5'd0, val, sl, pg, act};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		s_tvalid <= 1'b0;
	endtask

	task automatic quiesce();
		drop_valid();
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_bytes(input logic [3:0] n);
		record_bytes_wdata <= n;
		record_bytes_we <= 1'b1;
		@(negedge clk);
		record_bytes_we <= 1'b0;
	endtask

	// random burst of mostly well-formed traffic, mostly over pages 0 to 3
	task automatic random_phase(input int count);
		int burst;
		logic [1:0] act;
		logic [63:0] val;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				drop_valid();
				repeat ($urandom_range(0, 6)) @(negedge clk);
				burst = int'($urandom_range(1, 20));
			end
			burst--;
			act = 2'($urandom_range(0, 3));
			val = {$urandom, $urandom};
			if ($urandom_range(0, 9) == 0)
				send_req(act, 4'($urandom), 5'($urandom), val);
			else
				send_req(act, 4'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), val);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: inserts, extremes, not-live, deletes
		send_req(prss_pkg::ACT_INSERT, 4'hF, 5'h1F, 64'hFFFF_FFFF_FFFF_FFFF);
		send_req(prss_pkg::ACT_INSERT, 4'h0, 5'h00, 64'h0123_4567_89AB_CDEF);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h00, 64'hFFFF_FFFF_FFFF_FFFF);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h01, 64'h0);
		send_req(prss_pkg::ACT_UPDATE, 4'h0, 5'h01, 64'hA5A5_5A5A_0F0F_F0F0);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h01, 64'h0);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h02, 64'h0);
		send_req(prss_pkg::ACT_GET, 4'hF, 5'h1F, 64'h0);
		send_req(prss_pkg::ACT_UPDATE, 4'h7, 5'h10, 64'h1);
		send_req(prss_pkg::ACT_DELETE, 4'h0, 5'h00, 64'h0);
		send_req(prss_pkg::ACT_DELETE, 4'h0, 5'h00, 64'h0);
		send_req(prss_pkg::ACT_INSERT, 4'h0, 5'h00, 64'h8000_0000_0000_0001);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h00, 64'h0);
		quiesce();
		set_bytes(4'd1);
		send_req(prss_pkg::ACT_INSERT, 4'h0, 5'h00, 64'hFFFF_FFFF_FFFF_FFFF);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h02, 64'h0);
		quiesce();
		set_bytes(4'd0);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h01, 64'h0);
		quiesce();
		set_bytes(4'd15);
		send_req(prss_pkg::ACT_GET, 4'h0, 5'h01, 64'h0);
		// long receiver hold-off while requests keep coming
		hold_off = 1'b1;
		random_phase(40);
		quiesce();
		// fill the store to full and beyond
		for (int i = 0; i < 520; i++)
			send_req(prss_pkg::ACT_INSERT, 4'($urandom), 5'($urandom),
				{$urandom, $urandom});
		quiesce();
		for (int n = 1; n <= 9; n++) begin
			set_bytes(n[3:0]);
			random_phase(60);
			for (int i = 0; i < 20; i++)
				send_req(prss_pkg::ACT_DELETE, 4'($urandom_range(0, 15)), 5'($urandom),
					64'h0);
			quiesce();
		end
		set_bytes(4'd8);
		random_phase(30);
		quiesce();
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/prss_pkg.sv
src/paged_record_slot_store_top.sv
tb/prss_checker.sv
tb/tb.sv
